### rtl/ipf_pkg.sv
`default_nettype none

package ipf_pkg;

	localparam int MAX_POINTS_DEFAULT = 64;
	localparam int COORD_W = 16;
	localparam int RADIUS_W = 15;
	localparam int R2_W = 2 * RADIUS_W;
	localparam int INDEX_W = 6;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd200;
	localparam logic [R2_W-1:0] R2_RESET = R2_W'(RADIUS_RESET) * R2_W'(RADIUS_RESET);

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic last_point;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic [INDEX_W-1:0] point_index;
		logic none_kept;
		logic overflowed;
		logic last_result;
	} out_item_t;

	// One pair of points for the distance unit.
	typedef struct packed {
		logic valid;
		logic signed [COORD_W-1:0] a_x;
		logic signed [COORD_W-1:0] a_y;
		logic signed [COORD_W-1:0] b_x;
		logic signed [COORD_W-1:0] b_y;
	} dist_req_t;

	typedef struct packed {
		logic hit_valid;
		logic hit;
		logic busy;
	} dist_rsp_t;

endpackage

`default_nettype wire

### rtl/isolated_point_filter.sv
`default_nettype none

// Channel   Direction  Handshake                   Payload
// point     in         point_valid / point_ready   point  (in_item_t)
// result    out        result_valid / result_ready result (out_item_t)
// cfg       in         cfg_valid / cfg_ready       cfg_radius (15 bit)
//
// The transaction carrying last_point starts the neighbour check: every point is
// compared against every other stored point through the one distance unit, one
// pair a cycle from the single read port of the point memory, plus a short drain.
// Reset clears the control state only; the point memory needs no clearing pass.
// A stalled result transaction holds the check at its next kept point.

module isolated_point_filter import ipf_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                point_valid,
	output logic                     point_ready,
	input  wire in_item_t            point,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output out_item_t                result,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [RADIUS_W-1:0] cfg_radius
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_POINTS);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RD_I,
		ST_LAT_I,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_FINISH
	} state_t;

	state_t state_q;

	// Squared radius, worked out once when the register is written.
	logic [R2_W-1:0] r2_q, r2_d;

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [AW-1:0] i_q, j_q, last_idx;
	logic signed [COORD_W-1:0] xi_q, yi_q;
	logic          found_q;

	// The kept point waiting for the next one, so that the last of them can be
	// marked when the sweep ends.
	logic          pend_v_q;
	logic signed [COORD_W-1:0] pend_x_q, pend_y_q;
	logic [AW-1:0] pend_i_q;

	logic          rd_v_q, rd_self_q;
	logic          out_v_q;
	out_item_t     out_q;

	logic          accept, can_load, we, out_load;
	logic [AW-1:0] raddr;
	logic [2*COORD_W-1:0] rdata;
	dist_req_t     req;
	dist_rsp_t     rsp;

	assign r2_d = R2_W'(cfg_radius) * R2_W'(cfg_radius);
	assign cfg_ready = 1'b1;
	assign point_ready = (state_q == ST_LOAD);
	assign accept = point_valid && point_ready;
	assign we = accept && (count_q != FULL);
	assign raddr = (state_q == ST_SCAN) ? j_q : i_q;
	assign last_idx = AW'(count_q - CW'(1));
	assign can_load = !out_v_q || result_ready;
	// The output register takes a new result in this cycle.
	assign out_load = can_load && ((state_q == ST_FINISH)
		|| ((state_q == ST_DECIDE) && found_q && pend_v_q));
	assign result_valid = out_v_q;
	assign result = out_q;

	// Each candidate leaves the memory in the cycle after its address; a point is
	// never compared with itself.
	assign req.valid = rd_v_q && !rd_self_q;
	assign req.a_x = xi_q;
	assign req.a_y = yi_q;
	assign req.b_x = rdata[2*COORD_W-1:COORD_W];
	assign req.b_y = rdata[COORD_W-1:0];

	ipf_ram #(
		.WIDTH (2 * COORD_W),
		.DEPTH (MAX_POINTS)
	) u_points (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[AW-1:0]),
		.wdata ({point.point_x, point.point_y}),
		.raddr (raddr),
		.rdata (rdata)
	);

	ipf_dist_unit u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.r2     (r2_q),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			r2_q <= R2_RESET;
			count_q <= '0;
			ovf_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			xi_q <= '0;
			yi_q <= '0;
			found_q <= 1'b0;
			pend_v_q <= 1'b0;
			pend_x_q <= '0;
			pend_y_q <= '0;
			pend_i_q <= '0;
			rd_v_q <= 1'b0;
			rd_self_q <= 1'b0;
			out_v_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (cfg_valid) begin
				r2_q <= r2_d;
			end
			if (out_v_q && result_ready && !out_load) begin
				out_v_q <= 1'b0;
			end
			rd_v_q <= (state_q == ST_SCAN);
			rd_self_q <= (j_q == i_q);
			if (rsp.hit_valid && rsp.hit) begin
				found_q <= 1'b1;
			end

			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (count_q == FULL) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
						if (point.last_point) begin
							i_q <= '0;
							pend_v_q <= 1'b0;
							state_q <= ST_RD_I;
						end
					end
				end
				ST_RD_I: begin
					state_q <= ST_LAT_I;
				end
				ST_LAT_I: begin
					xi_q <= rdata[2*COORD_W-1:COORD_W];
					yi_q <= rdata[COORD_W-1:0];
					found_q <= 1'b0;
					j_q <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (j_q == last_idx) begin
						state_q <= ST_DRAIN;
					end else begin
						j_q <= j_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					if (!rd_v_q && !rsp.busy) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!(found_q && pend_v_q && !can_load)) begin
						if (found_q) begin
							if (pend_v_q) begin
								out_v_q <= 1'b1;
								out_q.out_x <= pend_x_q;
								out_q.out_y <= pend_y_q;
								out_q.point_index <= INDEX_W'(pend_i_q);
								out_q.none_kept <= 1'b0;
								out_q.overflowed <= ovf_q;
								out_q.last_result <= 1'b0;
							end
							pend_v_q <= 1'b1;
							pend_x_q <= xi_q;
							pend_y_q <= yi_q;
							pend_i_q <= i_q;
						end
						if (i_q == last_idx) begin
							state_q <= ST_FINISH;
						end else begin
							i_q <= i_q + AW'(1);
							state_q <= ST_RD_I;
						end
					end
				end
				ST_FINISH: begin
					if (can_load) begin
						out_v_q <= 1'b1;
						out_q.overflowed <= ovf_q;
						out_q.last_result <= 1'b1;
						if (pend_v_q) begin
							out_q.out_x <= pend_x_q;
							out_q.out_y <= pend_y_q;
							out_q.point_index <= INDEX_W'(pend_i_q);
							out_q.none_kept <= 1'b0;
						end else begin
							out_q.out_x <= '0;
							out_q.out_y <= '0;
							out_q.point_index <= '0;
							out_q.none_kept <= 1'b1;
						end
						count_q <= '0;
						ovf_q <= 1'b0;
						pend_v_q <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/ipf_ram.sv
`default_nettype none

module ipf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/ipf_dist_unit.sv
`default_nettype none

module ipf_dist_unit import ipf_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire dist_req_t       req,
	input  wire logic [R2_W-1:0] r2,
	output dist_rsp_t            rsp
);

	logic signed [COORD_W:0] dx, dy;
	logic [COORD_W-1:0] ax, ay;

	logic v_s1, v_s2, v_s3;
	logic [COORD_W-1:0] ax_s1, ay_s1;
	logic [2*COORD_W-1:0] sx_s2, sy_s2;
	logic hit_s3;
	logic [2*COORD_W:0] sum;

	always_comb begin
		dx = (COORD_W+1)'(req.a_x) - (COORD_W+1)'(req.b_x);
		dy = (COORD_W+1)'(req.a_y) - (COORD_W+1)'(req.b_y);
		ax = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
		ay = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
		sum = (2*COORD_W+1)'(sx_s2) + (2*COORD_W+1)'(sy_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1 <= ax;
		ay_s1 <= ay;
		sx_s2 <= ax_s1 * ax_s1;
		sy_s2 <= ay_s1 * ay_s1;
		hit_s3 <= sum <= (2*COORD_W+1)'(r2);
	end

	assign rsp.hit_valid = v_s3;
	assign rsp.hit = hit_s3;
	assign rsp.busy = v_s1 | v_s2 | v_s3;

endmodule

`default_nettype wire

### rtl/ipf_checker.sv
`default_nettype none

module ipf_checker import ipf_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                point_valid,
	input wire logic                point_ready,
	input wire in_item_t            point,
	input wire logic                result_valid,
	input wire logic                result_ready,
	input wire out_item_t           result,
	input wire logic                cfg_valid,
	input wire logic                cfg_ready
);

	// A waiting result must not change until it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// The empty answer closes the set and carries zero fields.
	a_none_kept_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.none_kept |-> result.last_result
			&& result.out_x == '0 && result.out_y == '0 && result.point_index == '0)
		else $error("malformed empty result");

	// Closing a set starts the check, so no further point is taken at once.
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && point_ready && point.last_point |=> !point_ready)
		else $error("point taken right after the closing point");

	// A radius write is always taken in the cycle it is offered.
	a_cfg_taken: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("radius write not taken");

endmodule

bind isolated_point_filter ipf_checker u_ipf_checker (.*);

`default_nettype wire

### tb/tb_isolated_point_filter.sv
`timescale 1ns / 100ps

// Testbench for the isolated point filter.
//
// Points are offered on the point channel one transaction at a time. A monitor
// watches every accepted point transaction and feeds it to a local filter
// model, which keeps its own copy of the point store and of the radius. When a
// set closes, the model works out which points have a neighbour and queues the
// result transactions that the block should produce. A checker pops that
// queue for every accepted result transaction and compares it field by field.
//
// The radius register is only written while the block is idle. That means all
// predicted results have arrived, and the block has had time to finish any
// comparisons it still runs after its final result.

module tb_isolated_point_filter;
	import ipf_pkg::*;

	localparam int CAPACITY = MAX_POINTS_DEFAULT;
	// Worst case for the neighbour check of a full set, plus some margin.
	localparam int SETTLE_CYCLES = CAPACITY * (CAPACITY + 8) + 100;
	localparam int DRAIN_LIMIT = 20000;
	localparam int RX_HOLD_CYCLES = 2000;
	localparam int RANDOM_ITEMS = 115;
	localparam int unsigned LIMIT_CYCLES = 800000;

	logic clk = 1'b0;
	logic arst_n;

	logic point_valid;
	logic point_ready;
	in_item_t point;
	logic result_valid;
	logic result_ready;
	out_item_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [RADIUS_W-1:0] cfg_radius;

	isolated_point_filter #(
		.MAX_POINTS(CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_ready(point_ready),
		.point(point),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_radius(cfg_radius)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Filter model state. It tracks the points of the set that is still open,
	// the overflow flag of that set, and the radius that the block holds.
	logic signed [COORD_W-1:0] ld_x [CAPACITY];
	logic signed [COORD_W-1:0] ld_y [CAPACITY];
	int ld_count = 0;
	bit ld_dropped = 1'b0;
	logic [RADIUS_W-1:0] radius_now = RADIUS_RESET;

	// Kept points (or the empty marker) still owed by the block, oldest first.
	out_item_t kept_due[$];

	int fail_count = 0;
	int unsigned cycle_count = 0;

	// Idling controls shared by the stimulus processes.
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	bit rx_hold = 1'b0;
	int rx_stall_left = 0;
	event hold_start;

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	function automatic longint sq_span(input int a, input int b);
		longint dx;
		longint dy;
		dx = longint'(ld_x[a]) - longint'(ld_x[b]);
		dy = longint'(ld_y[a]) - longint'(ld_y[b]);
		return dx * dx + dy * dy;
	endfunction

	// Adds one expected result behind those already owed.
	function automatic void owe_result(input out_item_t item);
		kept_due = {kept_due, item};
	endfunction

	// Stores one accepted point. A closing point runs the neighbour check over
	// the whole set and queues the kept points in load order.
	function automatic void load_and_filter(input in_item_t p);
		longint r2;
		bit any_kept;
		bit has_near;
		out_item_t kept;
		if (ld_count < CAPACITY) begin
			ld_x[ld_count] = p.point_x;
			ld_y[ld_count] = p.point_y;
			ld_count++;
		end else begin
			// Points beyond capacity are dropped, the closing one included.
			ld_dropped = 1'b1;
		end
		if (!p.last_point)
			return;
		r2 = longint'(radius_now) * longint'(radius_now);
		any_kept = 1'b0;
		for (int i = 0; i < ld_count; i++) begin
			has_near = 1'b0;
			for (int j = 0; j < ld_count; j++)
				if (i != j && sq_span(i, j) <= r2)
					has_near = 1'b1;
			if (has_near) begin
				kept = '0;
				kept.out_x = ld_x[i];
				kept.out_y = ld_y[i];
				kept.point_index = INDEX_W'(i);
				kept.overflowed = ld_dropped;
				owe_result(kept);
				any_kept = 1'b1;
			end
		end
		if (any_kept) begin
			kept = kept_due.pop_back();
			kept.last_result = 1'b1;
			owe_result(kept);
		end else begin
			// Nobody had a neighbour: a single empty result closes the set.
			kept = '0;
			kept.none_kept = 1'b1;
			kept.overflowed = ld_dropped;
			kept.last_result = 1'b1;
			owe_result(kept);
		end
		ld_count = 0;
		ld_dropped = 1'b0;
	endfunction

	// Monitors of the two input channels feed the model.
	always @(posedge clk) begin
		if (arst_n && point_valid && point_ready)
			load_and_filter(point);
		if (arst_n && cfg_valid && cfg_ready)
			radius_now = cfg_radius;
	end

	// Every accepted result transaction is held against the oldest prediction.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (kept_due.size() == 0) begin
				report_mismatch("result transaction with no prediction waiting");
			end else begin
				want = kept_due.pop_front();
				check_field("out_x", 32'(result.out_x), 32'(want.out_x));
				check_field("out_y", 32'(result.out_y), 32'(want.out_y));
				check_field("point_index", 32'(result.point_index), 32'(want.point_index));
				check_field("none_kept", 32'(result.none_kept), 32'(want.none_kept));
				check_field("overflowed", 32'(result.overflowed), 32'(want.overflowed));
				check_field("last_result", 32'(result.last_result), 32'(want.last_result));
			end
		end
	end

	// Mostly no gap, sometimes a short one, and now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Result receiver. It stalls at random while rx_gaps is set, and holds off
	// completely while a long hold is running.
	always begin
		@(negedge clk);
		if (rx_hold) begin
			result_ready <= 1'b0;
		end else if (rx_stall_left > 0) begin
			result_ready <= 1'b0;
			rx_stall_left--;
		end else begin
			result_ready <= 1'b1;
			if (rx_gaps)
				rx_stall_left = pick_gap();
		end
	end

	// The long hold is timed here, apart from the receiver itself.
	always begin
		@(hold_start);
		rx_hold = 1'b1;
		repeat (RX_HOLD_CYCLES) @(negedge clk);
		rx_hold = 1'b0;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic in_item_t mk_point(input int x, input int y, input bit last);
		in_item_t p;
		p.point_x = COORD_W'(x);
		p.point_y = COORD_W'(y);
		p.last_point = last;
		return p;
	endfunction

	// Offers one point and returns at the falling edge after it is accepted.
	// Valid is only lowered when a gap is due, so back-to-back transactions keep
	// it high.
	task automatic send_point(input in_item_t p);
		int gap;
		gap = tx_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			point_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		point <= p;
		point_valid <= 1'b1;
		do @(posedge clk); while (!point_ready);
		@(negedge clk);
	endtask

	// Sends a set of points scattered around a random centre. Coordinates that
	// run past the 16 bit range simply wrap.
	task automatic send_cloud(input int count, input int spread);
		int cx;
		int cy;
		cx = $urandom_range(0, 65535);
		cy = $urandom_range(0, 65535);
		for (int k = 0; k < count; k++)
			send_point(mk_point(cx + $urandom_range(0, 2 * spread) - spread,
				cy + $urandom_range(0, 2 * spread) - spread, k == count - 1));
	endtask

	// Waits until every predicted result has arrived and the block has had
	// time to finish its check.
	task automatic wait_for_idle();
		point_valid <= 1'b0;
		while (kept_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_radius(input logic [RADIUS_W-1:0] value);
		wait_for_idle();
		cfg_radius <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// The radius out of reset is 200: a pair at exactly that distance is kept,
	// and a pair just beyond it is not.
	task automatic test_reset_radius();
		send_point(mk_point(0, 0, 1'b0));
		send_point(mk_point(200, 0, 1'b1));
		send_point(mk_point(0, 0, 1'b0));
		send_point(mk_point(-120, -160, 1'b1));
		send_point(mk_point(0, 0, 1'b0));
		send_point(mk_point(120, 161, 1'b1));
	endtask

	// A lone point has nothing to compare with, so the set comes back empty.
	task automatic test_single_point();
		send_point(mk_point(-1, 32767, 1'b1));
	endtask

	task automatic test_extremes();
		// Opposite corners of the coordinate range lie further apart than the
		// largest radius.
		write_radius(15'h7FFF);
		send_point(mk_point(-32768, -32768, 1'b0));
		send_point(mk_point(32767, 32767, 1'b0));
		send_point(mk_point(32767, -32768, 1'b0));
		send_point(mk_point(-32768, 32767, 1'b1));
		// With a zero radius only coincident points count as neighbours.
		write_radius('0);
		send_point(mk_point(5, -5, 1'b0));
		send_point(mk_point(5, -5, 1'b0));
		send_point(mk_point(7, 7, 1'b1));
		// A distance equal to the largest radius still counts.
		write_radius(15'h7FFF);
		send_point(mk_point(0, 0, 1'b0));
		send_point(mk_point(32767, 0, 1'b0));
		send_point(mk_point(-1, -1, 1'b1));
	endtask

	// Two points more than the store can hold, so the closing point is
	// dropped as well and every result of the set carries the overflow flag.
	task automatic test_capacity();
		write_radius(15'd1000);
		send_cloud(CAPACITY + 2, 1000);
	endtask

	// The receiver holds off for a long stretch while the sender keeps going,
	// so the result side backs up and the block has to stall its input.
	task automatic test_back_pressure();
		int cx;
		int cy;
		wait_for_idle();
		tx_gaps = 1'b0;
		cx = $urandom_range(0, 65535);
		cy = $urandom_range(0, 65535);
		-> hold_start;
		// Coincident points are always kept, whatever the radius.
		for (int k = 0; k < 12; k++)
			send_point(mk_point(cx, cy, k == 11));
		send_cloud(8, int'(radius_now));
		tx_gaps = 1'b1;
	endtask

	// Random sets under a series of radius settings. Most sets are small and
	// clustered so that both kept and isolated points turn up; a few are large
	// enough to overflow, and some are spread over the whole range.
	task automatic test_random_sets();
		int sent;
		int count;
		int spread;
		logic [RADIUS_W-1:0] r;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 4))
				0: r = '0;
				1: r = 15'h7FFF;
				2: r = RADIUS_W'($urandom_range(1, 600));
				default: r = RADIUS_W'($urandom_range(0, 32767));
			endcase
			write_radius(r);
			tx_gaps = ($urandom_range(0, 3) != 0);
			rx_gaps = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(2, 6)) begin
				if ($urandom_range(0, 24) == 0)
					count = $urandom_range(40, CAPACITY + 6);
				else
					count = $urandom_range(1, 10);
				case ($urandom_range(0, 5)) inside
					0: spread = 0;
					1: spread = int'(r) / 2;
					[2:3]: spread = int'(r);
					4: spread = 2 * int'(r) + 1;
					default: spread = 32767;
				endcase
				send_cloud(count, spread);
				sent += count;
			end
		end
	endtask

	initial begin
		int drain_cycles;
		arst_n = 1'b0;
		point_valid = 1'b0;
		point = '0;
		result_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_radius = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_radius();
		test_single_point();
		test_extremes();
		test_capacity();
		test_back_pressure();
		test_random_sets();

		point_valid <= 1'b0;
		drain_cycles = 0;
		while (kept_due.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(negedge clk);
			drain_cycles++;
		end
		// Any late or spurious result transaction is caught by the checker.
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (kept_due.size() != 0)
			report_mismatch($sformatf("%0d predicted results never arrived",
				kept_due.size()));

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
